FILE: hdl/atzr_pkg.sv
// shared widths, stage counts and side-band types for the align-to-z rotation block
// no dependencies; imported by the square root, divider and top-level modules
`timescale 1ns / 1ps

package atzr_pkg;

	localparam int IN_W        = 16;
	localparam int MAG_W       = 16;
	localparam int SH_W        = 4;
	localparam int FRAC_BITS   = 14;
	localparam int GUARD_BITS  = 14;
	localparam int OUT_W       = FRAC_BITS + 2;
	localparam int UMAG_W      = FRAC_BITS + 1;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int SUM_W       = SQ_W + 2;
	localparam int DXY_W       = SQ_W + 1;
	localparam int RAD_W       = SUM_W + 2 * GUARD_BITS;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int SQRT_W      = RAD_W + 1;
	localparam int SQRT_STAGES = ROOT_W + 1;
	localparam int NUM_W       = 48;
	localparam int DEN_W       = SUM_W;
	localparam int QUO_W       = 17;
	localparam int DIV_STAGES  = QUO_W;
	localparam int ACC_W       = QUO_W + 2;

	localparam logic [UMAG_W-1:0] ONE_Q = UMAG_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [2:0]                neg;
		logic                      zero;
		logic                      ident;
		logic                      zneg;
		logic [2:0][MAG_W-1:0]     mag;
		logic [SQ_W-1:0]           sqx;
		logic [SQ_W-1:0]           sqy;
		logic [SQ_W-1:0]           pxy;
		logic [DXY_W-1:0]          dxy;
	} geo_t;

	typedef struct packed {
		logic [2:0]                neg;
		logic                      zero;
		logic                      ident;
		logic [2:0][UMAG_W-1:0]    umag;
	} unit_t;

endpackage

FILE: hdl/atzr_sqrt.sv
// pipelined integer square root, one result bit per register stage
// depends on atzr_pkg for widths and stage count
`timescale 1ns / 1ps

module atzr_sqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [atzr_pkg::RAD_W-1:0]   rad,
	output logic [atzr_pkg::ROOT_W-1:0]  root
);
	import atzr_pkg::*;

	logic [SQRT_W-1:0] n_s   [SQRT_STAGES];
	logic [SQRT_W-1:0] r_s   [SQRT_STAGES];
	logic [SQRT_W-1:0] n_in  [SQRT_STAGES];
	logic [SQRT_W-1:0] r_in  [SQRT_STAGES];

	always_comb begin
		n_in[0] = SQRT_W'(rad);
		r_in[0] = '0;
		for (int k = 1; k < SQRT_STAGES; k++) begin
			n_in[k] = n_s[k-1];
			r_in[k] = r_s[k-1];
		end
	end

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STAGES - 1 - k));
		logic [SQRT_W-1:0] trial;
		logic              take;
		assign trial = r_in[k] + BIT;
		assign take  = n_in[k] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k] <= take ? n_in[k] - trial : n_in[k];
				r_s[k] <= take ? (r_in[k] >> 1) + BIT : r_in[k] >> 1;
			end
		end
	end

	assign root = r_s[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

FILE: hdl/atzr_div.sv
// pipelined restoring divider with round-half-up, one quotient bit per stage
// depends on atzr_pkg; the quotient must stay below 2^QUO_W
`timescale 1ns / 1ps

module atzr_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [atzr_pkg::NUM_W-1:0]  num,
	input  logic [atzr_pkg::DEN_W-1:0]  den,
	output logic [atzr_pkg::QUO_W-1:0]  quo
);
	import atzr_pkg::*;

	localparam int REM_W = NUM_W + 1;
	localparam int CMP_W = DEN_W + QUO_W;

	logic [REM_W-1:0] rem_s  [DIV_STAGES];
	logic [DEN_W-1:0] den_s  [DIV_STAGES];
	logic [QUO_W-1:0] quo_s  [DIV_STAGES];
	logic [REM_W-1:0] rem_in [DIV_STAGES];
	logic [DEN_W-1:0] den_in [DIV_STAGES];
	logic [QUO_W-1:0] quo_in [DIV_STAGES];

	always_comb begin
		// half the divisor added up front gives the rounding
		rem_in[0] = REM_W'(num) + REM_W'(den >> 1);
		den_in[0] = den;
		quo_in[0] = '0;
		for (int k = 1; k < DIV_STAGES; k++) begin
			rem_in[k] = rem_s[k-1];
			den_in[k] = den_s[k-1];
			quo_in[k] = quo_s[k-1];
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [CMP_W-1:0] dsh;
		logic             take;
		assign dsh  = CMP_W'(den_in[k]) << (QUO_W - 1 - k);
		assign take = CMP_W'(rem_in[k]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? REM_W'(CMP_W'(rem_in[k]) - dsh) : rem_in[k];
				den_s[k] <= den_in[k];
				quo_s[k] <= quo_in[k] | (take ? QUO_W'(1) << (QUO_W - 1 - k) : '0);
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

FILE: hdl/align_to_z_rotation_matrix.sv
// rotation matrix that turns a direction onto +z, Q1.14 entries
// pipeline: 4 prep stages, 32 root stages, 17 unit-divide stages, 2 term stages,
// 17 term-divide stages and an output register
// throughput: one transfer per cycle; the whole pipeline holds while a result is stalled
// reset clears the valid bits only; uses atzr_pkg, atzr_sqrt, atzr_div
`timescale 1ns / 1ps

module align_to_z_rotation_matrix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               dir_valid,
	output logic                               dir_stall,
	input  logic signed [atzr_pkg::IN_W-1:0]   dir_x,
	input  logic signed [atzr_pkg::IN_W-1:0]   dir_y,
	input  logic signed [atzr_pkg::IN_W-1:0]   dir_z,
	output logic                               mat_valid,
	input  logic                               mat_stall,
	output logic signed [atzr_pkg::OUT_W-1:0]  m00,
	output logic signed [atzr_pkg::OUT_W-1:0]  m01,
	output logic signed [atzr_pkg::OUT_W-1:0]  m02,
	output logic signed [atzr_pkg::OUT_W-1:0]  m10,
	output logic signed [atzr_pkg::OUT_W-1:0]  m11,
	output logic signed [atzr_pkg::OUT_W-1:0]  m12,
	output logic signed [atzr_pkg::OUT_W-1:0]  m20,
	output logic signed [atzr_pkg::OUT_W-1:0]  m21,
	output logic signed [atzr_pkg::OUT_W-1:0]  m22,
	output logic                               zero_input
);
	import atzr_pkg::*;

	function automatic logic [SH_W-1:0] lead_zeros(logic [MAG_W-1:0] v);
		logic [SH_W-1:0] sh;
		sh = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (v[i]) sh = SH_W'(MAG_W - 1 - i);
		end
		return sh;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] one;
		one = $signed(ACC_W'(ONE_Q));
		if (v > one) return OUT_W'(one);
		if (v < -one) return OUT_W'(-one);
		return OUT_W'(v);
	endfunction

	logic adv;
	assign adv       = !mat_valid || !mat_stall;
	assign dir_stall = !adv;

	// stage 1: sign and magnitude
	logic [2:0][IN_W-1:0]   din;
	logic [2:0]             neg_s1;
	logic [2:0][MAG_W-1:0]  mag_s1;
	logic                   vld_s1;

	assign din = {dir_z, dir_y, dir_x};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= din[i][IN_W-1];
				mag_s1[i] <= MAG_W'(din[i][IN_W-1] ? ~din[i] + 1'b1 : din[i]);
			end
		end
	end

	// stage 2: block scaling so the largest magnitude has its top bit set
	logic [MAG_W-1:0]       mx;
	logic [SH_W-1:0]        sh;
	logic [2:0]             neg_s2;
	logic [2:0][MAG_W-1:0]  mag_s2;
	logic                   zero_s2;
	logic                   vld_s2;

	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) mx = mag_s1[1];
		if (mag_s1[2] > mx) mx = mag_s1[2];
		sh = lead_zeros(mx);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2  <= neg_s1;
			zero_s2 <= mx == '0;
			for (int i = 0; i < 3; i++) mag_s2[i] <= mag_s1[i] << sh;
		end
	end

	// stage 3: squares and the x*y product
	logic [SQ_W-1:0]        sqx_s3, sqy_s3, sqz_s3, pxy_s3;
	logic [2:0]             neg_s3;
	logic [2:0][MAG_W-1:0]  mag_s3;
	logic                   zero_s3, ident_s3, zneg_s3;
	logic                   vld_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s3   <= mag_s2[0] * mag_s2[0];
			sqy_s3   <= mag_s2[1] * mag_s2[1];
			sqz_s3   <= mag_s2[2] * mag_s2[2];
			pxy_s3   <= mag_s2[0] * mag_s2[1];
			neg_s3   <= neg_s2;
			mag_s3   <= mag_s2;
			zero_s3  <= zero_s2;
			// along -z: identity without the zero flag
			ident_s3 <= mag_s2[0] == '0 && mag_s2[1] == '0 && mag_s2[2] != '0 && neg_s2[2];
			zneg_s3  <= neg_s2[2] && mag_s2[2] != '0;
		end
	end

	// stage 4: sums of squares
	geo_t               geo_s4;
	logic [RAD_W-1:0]   rad_s4;
	logic               vld_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s4.neg   <= neg_s3;
			geo_s4.zero  <= zero_s3;
			geo_s4.ident <= ident_s3;
			geo_s4.zneg  <= zneg_s3;
			geo_s4.mag   <= mag_s3;
			geo_s4.sqx   <= sqx_s3;
			geo_s4.sqy   <= sqy_s3;
			geo_s4.pxy   <= pxy_s3;
			geo_s4.dxy   <= DXY_W'(sqx_s3) + DXY_W'(sqy_s3);
			rad_s4       <= RAD_W'(SUM_W'(sqx_s3) + SUM_W'(sqy_s3) + SUM_W'(sqz_s3))
				<< (2 * GUARD_BITS);
		end
	end

	// length
	logic [ROOT_W-1:0] lq;
	geo_t              geo_sq_s [SQRT_STAGES];
	logic              vld_sq_s [SQRT_STAGES];

	atzr_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s4),
		.root (lq)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_sq_s[0] <= geo_s4;
			for (int k = 1; k < SQRT_STAGES; k++) geo_sq_s[k] <= geo_sq_s[k-1];
		end
	end

	// unit components
	logic [2:0][QUO_W-1:0] uq;
	geo_t                  geo_ud_s [DIV_STAGES];
	logic                  vld_ud_s [DIV_STAGES];

	for (genvar i = 0; i < 3; i++) begin : g_udiv
		atzr_div u_div (
			.clk (clk),
			.en  (adv),
			.num (NUM_W'(geo_sq_s[SQRT_STAGES-1].mag[i]) << (FRAC_BITS + GUARD_BITS)),
			.den (DEN_W'(lq)),
			.quo (uq[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_ud_s[0] <= geo_sq_s[SQRT_STAGES-1];
			for (int k = 1; k < DIV_STAGES; k++) geo_ud_s[k] <= geo_ud_s[k-1];
		end
	end

	// stage 5: clamp unit components
	geo_t                   geo_s5;
	logic [2:0][UMAG_W-1:0] umag_s5;
	logic                   vld_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s5 <= geo_ud_s[DIV_STAGES-1];
			for (int i = 0; i < 3; i++)
				umag_s5[i] <= uq[i] > QUO_W'(ONE_Q) ? ONE_Q : uq[i][UMAG_W-1:0];
		end
	end

	// stage 6: numerators and denominators of the T terms (xx, yy, xy)
	logic [UMAG_W:0]           onez;
	logic [2:0][SQ_W-1:0]      pterm;
	logic [2:0][UMAG_W-1:0]    ua, ub;
	logic [2:0][NUM_W-1:0]     tnum_s6;
	logic [2:0][DEN_W-1:0]     tden_s6;
	unit_t                     unit_s6;
	logic                      vld_s6;

	always_comb begin
		onez     = (UMAG_W + 1)'(ONE_Q) + (UMAG_W + 1)'(umag_s5[2]);
		pterm[0] = geo_s5.sqx;
		pterm[1] = geo_s5.sqy;
		pterm[2] = geo_s5.pxy;
		ua[0]    = umag_s5[0];
		ub[0]    = umag_s5[0];
		ua[1]    = umag_s5[1];
		ub[1]    = umag_s5[1];
		ua[2]    = umag_s5[0];
		ub[2]    = umag_s5[1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				// below the xy plane the form in scaled components avoids cancellation
				if (geo_s5.zneg) begin
					tnum_s6[i] <= NUM_W'(onez) * NUM_W'(pterm[i]);
					tden_s6[i] <= DEN_W'(geo_s5.dxy);
				end else begin
					tnum_s6[i] <= NUM_W'(SQ_W'(ua[i]) * SQ_W'(ub[i]));
					tden_s6[i] <= DEN_W'(onez);
				end
			end
			unit_s6.neg   <= geo_s5.neg;
			unit_s6.zero  <= geo_s5.zero;
			unit_s6.ident <= geo_s5.ident;
			unit_s6.umag  <= umag_s5;
		end
	end

	// T terms
	logic [2:0][QUO_W-1:0] tq;
	unit_t                 unit_td_s [DIV_STAGES];
	logic                  vld_td_s  [DIV_STAGES];

	for (genvar i = 0; i < 3; i++) begin : g_tdiv
		atzr_div u_div (
			.clk (clk),
			.en  (adv),
			.num (tnum_s6[i]),
			.den (tden_s6[i]),
			.quo (tq[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_td_s[0] <= unit_s6;
			for (int k = 1; k < DIV_STAGES; k++) unit_td_s[k] <= unit_td_s[k-1];
		end
	end

	// output stage: assemble matrix
	unit_t                    uo;
	logic signed [ACC_W-1:0]  one_a;
	logic signed [ACC_W-1:0]  d00, d11, dxy;
	logic signed [OUT_W-1:0]  ux, uy, uz;
	logic signed [OUT_W-1:0]  one_o;

	always_comb begin
		uo    = unit_td_s[DIV_STAGES-1];
		one_a = $signed(ACC_W'(ONE_Q));
		one_o = $signed(OUT_W'(ONE_Q));
		d00   = one_a - $signed({2'b00, tq[0]});
		d11   = one_a - $signed({2'b00, tq[1]});
		dxy   = uo.neg[0] != uo.neg[1] ? $signed({2'b00, tq[2]}) : -$signed({2'b00, tq[2]});
		ux    = uo.neg[0] ? -$signed({1'b0, uo.umag[0]}) : $signed({1'b0, uo.umag[0]});
		uy    = uo.neg[1] ? -$signed({1'b0, uo.umag[1]}) : $signed({1'b0, uo.umag[1]});
		uz    = uo.neg[2] ? -$signed({1'b0, uo.umag[2]}) : $signed({1'b0, uo.umag[2]});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_input <= uo.zero;
			if (uo.zero || uo.ident) begin
				m00 <= one_o;
				m01 <= '0;
				m02 <= '0;
				m10 <= '0;
				m11 <= one_o;
				m12 <= '0;
				m20 <= '0;
				m21 <= '0;
				m22 <= one_o;
			end else begin
				m00 <= sat(d00);
				m01 <= sat(dxy);
				m02 <= -ux;
				m10 <= sat(dxy);
				m11 <= sat(d11);
				m12 <= -uy;
				m20 <= ux;
				m21 <= uy;
				m22 <= uz;
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			mat_valid <= 1'b0;
			for (int k = 0; k < SQRT_STAGES; k++) vld_sq_s[k] <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				vld_ud_s[k] <= 1'b0;
				vld_td_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1      <= dir_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_sq_s[0] <= vld_s4;
			for (int k = 1; k < SQRT_STAGES; k++) vld_sq_s[k] <= vld_sq_s[k-1];
			vld_ud_s[0] <= vld_sq_s[SQRT_STAGES-1];
			for (int k = 1; k < DIV_STAGES; k++) vld_ud_s[k] <= vld_ud_s[k-1];
			vld_s5      <= vld_ud_s[DIV_STAGES-1];
			vld_s6      <= vld_s5;
			vld_td_s[0] <= vld_s6;
			for (int k = 1; k < DIV_STAGES; k++) vld_td_s[k] <= vld_td_s[k-1];
			mat_valid   <= vld_td_s[DIV_STAGES-1];
		end
	end

endmodule

FILE: tb/sv/align_to_z_rotation_matrix_test.sv
// self-checking bench for align_to_z_rotation_matrix: directed and random directions,
// a predicted matrix per transfer compared at the output; uses atzr_pkg for widths
`timescale 1ns / 1ps

class rotation_scoreboard;
	typedef struct {
		logic signed [15:0] m [9];
		logic zero;
	} matrix_t;

	matrix_t pending[$];
	int errors;

	function longint unsigned isqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function longint unsigned rdiv(longint unsigned num, longint unsigned den);
		return (num + den / 2) / den;
	endfunction

	function longint clampq(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	// works out the matrix for one direction and queues it
	function void note_direction(logic signed [15:0] dx, logic signed [15:0] dy,
			logic signed [15:0] dz);
		longint unsigned mag[3], umag[3], tm[3], mx, s, lq, q;
		logic neg[3];
		longint c[3], u[3], mm[9], txy;
		matrix_t r;
		int a, b;
		mx = 0;
		c[0] = dx; c[1] = dy; c[2] = dz;
		for (int i = 0; i < 3; i++) begin
			neg[i] = c[i] < 0;
			mag[i] = neg[i] ? -c[i] : c[i];
			if (mag[i] > mx) mx = mag[i];
		end
		for (int i = 0; i < 9; i++) mm[i] = 0;
		mm[0] = 16384; mm[4] = 16384; mm[8] = 16384;
		r.zero = (mx == 0);
		if (mx != 0) begin
			while (mx >= 65536) begin
				for (int i = 0; i < 3; i++) mag[i] >>= 1;
				mx >>= 1;
			end
			while (mx < 32768) begin
				for (int i = 0; i < 3; i++) mag[i] <<= 1;
				mx <<= 1;
			end
			// along -z stays identity
			if (!(mag[0] == 0 && mag[1] == 0 && mag[2] != 0 && neg[2])) begin
				s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
				lq = isqrt(s << 28);
				for (int i = 0; i < 3; i++) begin
					q = rdiv(mag[i] << 28, lq);
					if (q > 16384) q = 16384;
					umag[i] = q;
					u[i] = neg[i] ? -longint'(q) : longint'(q);
				end
				for (int i = 0; i < 3; i++) begin
					a = (i == 1) ? 1 : 0;
					b = (i == 0) ? 0 : 1;
					if (!neg[2] || mag[2] == 0)
						tm[i] = rdiv(umag[a] * umag[b], 16384 + umag[2]);
					else
						tm[i] = rdiv((16384 + umag[2]) * mag[a] * mag[b],
							mag[0] * mag[0] + mag[1] * mag[1]);
				end
				txy = (neg[0] != neg[1]) ? -longint'(tm[2]) : longint'(tm[2]);
				mm[0] = 16384 - longint'(tm[0]);
				mm[1] = -txy; mm[2] = -u[0]; mm[3] = -txy;
				mm[4] = 16384 - longint'(tm[1]);
				mm[5] = -u[1]; mm[6] = u[0]; mm[7] = u[1]; mm[8] = u[2];
			end
		end
		for (int i = 0; i < 9; i++) r.m[i] = 16'(clampq(mm[i]));
		pending.push_back(r);
	endfunction

	task report(string msg);
		$display("%s", msg);
		errors++;
	endtask

	task check_matrix(logic signed [15:0] got[9], logic got_zero);
		matrix_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected matrix transfer at %0t", $realtime));
			return;
		end
		e = pending.pop_front();
		for (int i = 0; i < 9; i++)
			if (got[i] !== e.m[i])
				report($sformatf("m%0d%0d: got %0d, want %0d", i / 3, i % 3,
					got[i], e.m[i]));
		if (got_zero !== e.zero)
			report($sformatf("zero_input: got %b, want %b", got_zero, e.zero));
	endtask
endclass

module align_to_z_rotation_matrix_test;
	import atzr_pkg::*;

	logic clk = 0, arst_n = 0;
	logic dir_valid = 0, mat_stall = 0;
	logic dir_stall, mat_valid, zero_input;
	logic signed [IN_W-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic signed [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic hold_off = 0;
	int cycle_count = 0;
	bit inputs_done = 0;
	rotation_scoreboard matrices = new();

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	align_to_z_rotation_matrix u_top (.*);

	function int gap_length();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
			($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
	endfunction

	task send_direction(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
		dir_x <= x; dir_y <= y; dir_z <= z;
		dir_valid <= 1;
		do @(posedge clk); while (dir_stall);
		matrices.note_direction(x, y, z);
		@(negedge clk);
	endtask

	task idle_sender(int n);
		dir_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	function logic signed [15:0] random_component();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 4)) - 16'sd2;
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: return 16'($urandom_range(0, 255)) - 16'sd128;
			default: return 16'($urandom);
		endcase
	endfunction

	// directed corners then random directions
	initial begin
		logic signed [15:0] x, y;
		int gap;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_direction(0, 0, 0);
		send_direction(0, 0, 1);
		send_direction(0, 0, -1);
		send_direction(0, 0, 16'sh7fff);
		send_direction(0, 0, 16'sh8000);
		send_direction(16'sh7fff, 0, 0);
		send_direction(16'sh8000, 0, 0);
		send_direction(0, 16'sh8000, 0);
		send_direction(16'sh8000, 16'sh8000, 16'sh8000);
		send_direction(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_direction(1, 0, 16'sh8000);
		send_direction(-1, 1, -30000);
		send_direction(1, -1, 30000);
		send_direction(3, -4, -5);
		send_direction(16'sh8000, 16'sh7fff, -1);
		send_direction(-1, -1, -1);
		send_direction(100, -200, 16'sh8000);
		send_direction(16'sh5555, 16'shaaaa, 16'sh5555);
		// sender pauses until the pipeline has drained
		idle_sender(1);
		while (matrices.pending.size() != 0) @(negedge clk);
		for (int n = 0; n < 1150; n++) begin
			x = random_component();
			y = random_component();
			if ($urandom_range(0, 9) == 0) begin
				// near the z axis
				x = 16'($urandom_range(0, 6)) - 16'sd3;
				y = 16'($urandom_range(0, 6)) - 16'sd3;
			end
			send_direction(x, y, random_component());
			if (n == 300) begin
				hold_off <= 1;
				while (!dir_stall) send_direction(random_component(),
					random_component(), random_component());
			end
			gap = gap_length();
			if (gap != 0) idle_sender(gap);
		end
		dir_valid <= 0;
		inputs_done = 1;
	end

	// receiver: random stalls plus one long hold-off
	initial begin
		int stretch;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off && !held) begin
				mat_stall <= 1;
				repeat (200) @(negedge clk);
				held = 1;
			end
			stretch = gap_length();
			mat_stall <= (stretch != 0);
			if (stretch > 1) repeat (stretch - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		logic signed [15:0] got[9];
		if (arst_n && mat_valid && !mat_stall) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			matrices.check_matrix(got, zero_input);
		end
	end

	initial begin
		int limit;
		limit = 600000;
		while (!(inputs_done && matrices.pending.size() == 0) && cycle_count < limit) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= limit) begin
			$display("align_to_z_rotation_matrix verification failed");
		end else begin
			repeat (150) @(posedge clk);
			if (matrices.errors == 0 && matrices.pending.size() == 0)
				$display("align_to_z_rotation_matrix verification clean");
			else
				$display("align_to_z_rotation_matrix verification failed");
		end
		$finish;
	end
endmodule

FILE: align_to_z_rotation_matrix.f
hdl/atzr_pkg.sv
hdl/atzr_sqrt.sv
hdl/atzr_div.sv
hdl/align_to_z_rotation_matrix.sv
tb/sv/align_to_z_rotation_matrix_test.sv
